// ===== src/brf_pkg.sv =====
// Shared types and constants for the circular byte queue with rewind.
// Field widths, operation codes and the controller/datapath handshake structs.
// No dependencies.
`default_nettype none

package brf_pkg;

  localparam int KIND_W = 3;
  localparam int DATA_W = 8;
  localparam int AMT_W  = 9;
  localparam int CAP_W  = 9;
  localparam int CNT_W  = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REWIND  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FORWARD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

  typedef struct packed {
    logic accept;
    logic exec;
    logic mod_step;
    logic clr_step;
    logic load_out;
  } brf_cmd_t;

  typedef struct packed {
    logic need_mod;
    logic mod_last;
    logic clr_last;
    logic out_full;
  } brf_sts_t;

endpackage

`default_nettype wire

// ===== src/brf_ctrl.sv =====
// Controller for the byte queue: clearing pass, execute, modulo and result sequencing.
// Depends on brf_pkg for the command and status structs.
`default_nettype none

module brf_ctrl import brf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic     out_stall,
  input  wire brf_sts_t sts,
  output brf_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_EXEC,
    ST_MOD,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_mod ? ST_MOD : ST_DONE;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_full || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_EXEC)
    else $error("accepted beat not executed");

  a_done_leave: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && !out_stall |=> state_r == ST_IDLE)
    else $error("result not delivered while output free");

  a_mod_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MOD |-> $past(state_r) == ST_EXEC || $past(state_r) == ST_MOD)
    else $error("modulo step without forward");

endmodule

`default_nettype wire

// ===== src/brf_dpath.sv =====
// Datapath for the byte queue: pointers, count, capacity, byte store, modulo unit
// and output register. Depends on brf_pkg; driven by brf_ctrl commands.
`default_nettype none

module brf_dpath import brf_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [DATA_W-1:0] in_data_byte,
  input  wire logic [AMT_W-1:0]  in_amount,
  input  wire logic              cfg_wr_en,
  input  wire logic [CAP_W-1:0]  cfg_wr_data,
  input  wire logic              out_stall,
  input  wire brf_cmd_t          cmd,
  output brf_sts_t               sts,
  output logic                   out_valid,
  output logic [DATA_W-1:0]      out_read_data,
  output logic                   out_read_valid,
  output logic                   out_refused,
  output logic [CNT_W-1:0]       out_fill_count
);

  localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AW  = ((PW > CAP_W) ? PW : CAP_W) + 2;
  localparam int MCW = $clog2(AW);

  function automatic logic [AW-1:0] eff_cap(input logic [CAP_W-1:0] c);
    logic [AW-1:0] e;
    e = AW'(c);
    if (e == '0) e = AW'(1);
    if (e > AW'(DEPTH)) e = AW'(DEPTH);
    return e;
  endfunction

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q_r;

  logic [AW-1:0]     cap_r;
  logic [PW-1:0]     rp_r, wp_r, clr_addr_r;
  logic [CNT_W-1:0]  held_r;
  logic [KIND_W-1:0] op_kind_r;
  logic [DATA_W-1:0] op_data_r;
  logic [AMT_W-1:0]  op_amt_r;
  logic              res_rvalid_r, res_refused_r, out_valid_r;
  logic [AW-1:0]     rem_r;
  logic [2*AW-2:0]   dvs_r;
  logic [MCW-1:0]    mcnt_r;

  logic [AW-1:0] rp_e, wp_e, held_e, amt_e;
  logic [AW-1:0] wp_inc, rp_inc, rew_sum, rew_rp, fwd_sum, fwd_sub, rem_nxt;
  logic [PW-1:0] wp_adv, rp_adv;
  logic          rew_ref, fwd_ref, fwd_lt, fwd_big, rem_ge, held_nz;
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  assign rp_e    = AW'(rp_r);
  assign wp_e    = AW'(wp_r);
  assign held_e  = AW'(held_r);
  assign amt_e   = AW'(op_amt_r);
  assign held_nz = (held_r != '0);

  assign wp_inc = wp_e + AW'(1);
  assign rp_inc = rp_e + AW'(1);
  assign wp_adv = (wp_inc >= cap_r) ? '0 : wp_inc[PW-1:0];
  assign rp_adv = (rp_inc >= cap_r) ? '0 : rp_inc[PW-1:0];

  assign rew_sum = held_e + amt_e;
  assign rew_ref = (rew_sum > cap_r);
  assign rew_rp  = (rp_e < amt_e) ? cap_r - (amt_e - rp_e) : rp_e - amt_e;

  assign fwd_sum = rp_e + amt_e;
  assign fwd_ref = (held_e < amt_e);
  assign fwd_sub = fwd_sum - cap_r;
  assign fwd_lt  = (fwd_sum < cap_r);
  assign fwd_big = (fwd_sum >= (cap_r << 1));

  assign rem_ge  = ({{(AW-1){1'b0}}, rem_r} >= dvs_r);
  assign rem_nxt = rem_ge ? rem_r - dvs_r[AW-1:0] : rem_r;

  assign sts.need_mod = (op_kind_r == KIND_FORWARD) && !fwd_ref && fwd_big;
  assign sts.mod_last = (mcnt_r == '0);
  assign sts.clr_last = (clr_addr_r == PW'(DEPTH - 1));
  assign sts.out_full = out_valid_r;
  assign out_valid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= eff_cap(CAP_RESET);
      rp_r        <= '0;
      wp_r        <= '0;
      held_r      <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) cap_r <= eff_cap(cfg_wr_data);
      if (cmd.clr_step) clr_addr_r <= clr_addr_r + PW'(1);
      if (cmd.exec) begin
        case (op_kind_r)
          KIND_WRITE: begin
            wp_r <= wp_adv;
            if (held_e < cap_r) held_r <= held_r + CNT_W'(1);
          end
          KIND_READ: begin
            if (held_nz) begin
              held_r <= held_r - CNT_W'(1);
              rp_r   <= rp_adv;
            end
          end
          KIND_REWIND: begin
            if (!rew_ref) begin
              rp_r   <= rew_rp[PW-1:0];
              held_r <= rew_sum[CNT_W-1:0];
            end
          end
          KIND_FORWARD: begin
            if (!fwd_ref) begin
              held_r <= held_r - op_amt_r;
              if (fwd_lt) rp_r <= fwd_sum[PW-1:0];
              else if (!fwd_big) rp_r <= fwd_sub[PW-1:0];
            end
          end
          KIND_CLEAR: begin
            rp_r   <= '0;
            wp_r   <= '0;
            held_r <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.mod_step && sts.mod_last) rp_r <= rem_nxt[PW-1:0];
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_kind_r <= in_kind;
      op_data_r <= in_data_byte;
      op_amt_r  <= in_amount;
    end
    if (cmd.exec) begin
      res_rvalid_r  <= (op_kind_r == KIND_READ) && held_nz;
      res_refused_r <= ((op_kind_r == KIND_REWIND) && rew_ref) ||
                       ((op_kind_r == KIND_FORWARD) && fwd_ref);
      if (sts.need_mod) begin
        rem_r  <= fwd_sum;
        dvs_r  <= {cap_r, {(AW-1){1'b0}}};
        mcnt_r <= MCW'(AW - 1);
      end
    end
    if (cmd.mod_step) begin
      rem_r  <= rem_nxt;
      dvs_r  <= dvs_r >> 1;
      mcnt_r <= mcnt_r - MCW'(1);
    end
    if (cmd.load_out) begin
      out_read_data  <= res_rvalid_r ? mem_q_r : '0;
      out_read_valid <= res_rvalid_r;
      out_refused    <= res_refused_r;
      out_fill_count <= held_r;
    end
  end

  assign mem_we    = cmd.clr_step || (cmd.exec && (op_kind_r == KIND_WRITE));
  assign mem_waddr = cmd.clr_step ? clr_addr_r : wp_r;
  assign mem_wdata = cmd.clr_step ? '0 : op_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.exec && (op_kind_r == KIND_READ)) mem_q_r <= mem[rp_r];
  end

  a_write_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && op_kind_r == KIND_WRITE |=> held_r != '0)
    else $error("count zero after write");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    AW'(rp_r) < AW'(DEPTH) && AW'(wp_r) < AW'(DEPTH))
    else $error("pointer beyond store depth");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && op_kind_r == KIND_CLEAR |=> held_r == '0 && rp_r == '0 && wp_r == '0)
    else $error("clear left state behind");

endmodule

`default_nettype wire

// ===== src/byte_ring_fifo_with_rewind_unit.sv =====
// Sequence: an accepted operation is executed, a forward whose read position reaches
// twice the capacity or more then steps through the modulo unit, and the result is
// loaded into the output register; a new operation is taken only after that load.
// Reset: pointers and count to zero, capacity 256; then a clearing pass over every
// address zeroes the byte store with in_stall high. Top level; uses brf_pkg, brf_ctrl, brf_dpath.
`default_nettype none

module byte_ring_fifo_with_rewind_unit import brf_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [DATA_W-1:0] in_data_byte,
  input  wire logic [AMT_W-1:0]  in_amount,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [DATA_W-1:0]      out_read_data,
  output logic                   out_read_valid,
  output logic                   out_refused,
  output logic [CNT_W-1:0]       out_fill_count,
  input  wire logic              cfg_wr_en,
  input  wire logic [CAP_W-1:0]  cfg_wr_data
);

  brf_cmd_t cmd;
  brf_sts_t sts;

  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  brf_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_kind        (in_kind),
    .in_data_byte   (in_data_byte),
    .in_amount      (in_amount),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_stall      (out_stall),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data),
    .out_read_valid (out_read_valid),
    .out_refused    (out_refused),
    .out_fill_count (out_fill_count)
  );

endmodule

`default_nettype wire

// ===== bench/tb_byte_ring_fifo_with_rewind_unit.sv =====
// Self-checking bench for byte_ring_fifo_with_rewind_unit: directed table, then random phases.
// Predicts results from a local queue model (or table values where a directed row gives them)
// and checks every output beat in order. Depends on brf_pkg and the unit under test.
`timescale 1ns / 100ps

module tb_byte_ring_fifo_with_rewind_unit;
  import brf_pkg::*;

  localparam int DEPTH = 256;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX = 10;

  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              read_valid;
    logic              refused;
    logic [CNT_W-1:0]  fill_count;
  } fifo_result_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] data_byte;
    logic [AMT_W-1:0]  amount;
    logic              has_exp;
    fifo_result_t      exp_res;
  } op_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] in_kind = KIND_WRITE;
  logic [DATA_W-1:0] in_data_byte = '0;
  logic [AMT_W-1:0] in_amount = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DATA_W-1:0] out_read_data;
  logic out_read_valid;
  logic out_refused;
  logic [CNT_W-1:0] out_fill_count;
  logic cfg_wr_en = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;

  byte_ring_fifo_with_rewind_unit #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_data_byte(in_data_byte),
    .in_amount(in_amount),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_read_data(out_read_data),
    .out_read_valid(out_read_valid),
    .out_refused(out_refused),
    .out_fill_count(out_fill_count),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  // queue model state
  logic [DATA_W-1:0] model_mem [DEPTH];
  int model_rd = 0;
  int model_wr = 0;
  int model_fill = 0;
  int model_cap = int'(CAP_RESET);

  fifo_result_t pending_results[$];
  int errors = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int refused_seen = 0;
  int reads_hit = 0;
  int max_fill = 0;
  int caps_used = 1;
  int cycle_cnt = 0;

  int idle_pct = 0;
  int stall_pct = 0;
  bit want_hold = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  function automatic int eff_cap();
    if (model_cap == 0) return 1;
    if (model_cap > DEPTH) return DEPTH;
    return model_cap;
  endfunction

  function automatic fifo_result_t queue_model_step(logic [KIND_W-1:0] kind,
                                                    logic [DATA_W-1:0] data,
                                                    logic [AMT_W-1:0] amt);
    fifo_result_t res;
    int ec;
    int a;
    res = '0;
    ec = eff_cap();
    a = int'(amt);
    case (kind)
      KIND_WRITE: begin
        if (model_fill < ec) model_fill++;
        model_mem[model_wr % DEPTH] = data;
        model_wr = (model_wr + 1 >= ec) ? 0 : model_wr + 1;
      end
      KIND_READ: begin
        if (model_fill > 0) begin
          model_fill--;
          res.read_data = model_mem[model_rd % DEPTH];
          res.read_valid = 1'b1;
          model_rd = (model_rd + 1 >= ec) ? 0 : model_rd + 1;
        end
      end
      KIND_REWIND: begin
        if (model_fill + a > ec) begin
          res.refused = 1'b1;
        end else begin
          if (model_rd < a) model_rd = ec - (a - model_rd);
          else model_rd = model_rd - a;
          model_fill += a;
        end
      end
      KIND_FORWARD: begin
        if (model_fill < a) begin
          res.refused = 1'b1;
        end else begin
          model_rd = (model_rd + a) % ec;
          model_fill -= a;
        end
      end
      KIND_CLEAR: begin
        model_fill = 0;
        model_rd = 0;
        model_wr = 0;
      end
      default: ;
    endcase
    res.fill_count = CNT_W'(model_fill);
    return res;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  // receiver side: random stall, plus a long hold-off on request
  always @(posedge clk) begin
    if (want_hold && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
    if (!want_hold) hold_seen <= 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    fifo_result_t got;
    fifo_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_read_data, out_read_valid, out_refused, out_fill_count};
      if (pending_results.size() == 0) begin
        if (errors < REPORT_MAX)
          $display("unexpected beat: data %02h valid %0b refused %0b fill %0d",
                   got.read_data, got.read_valid, got.refused, got.fill_count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        beats_checked++;
        if (got !== want) begin
          if (errors < REPORT_MAX)
            $display("mismatch beat %0d: exp data %02h valid %0b refused %0b fill %0d,%s",
                     beats_checked, want.read_data, want.read_valid, want.refused,
                     want.fill_count, " got");
          if (errors < REPORT_MAX)
            $display("  data %02h valid %0b refused %0b fill %0d",
                     got.read_data, got.read_valid, got.refused, got.fill_count);
          errors++;
        end
      end
    end
  end

  task automatic send_op(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] data,
                         logic [AMT_W-1:0] amt, logic has_exp, fifo_result_t exp_res);
    fifo_result_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_data_byte <= data;
    in_amount <= amt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = queue_model_step(kind, data, amt);
    if (res.refused) refused_seen++;
    if (res.read_valid) reads_hit++;
    if (model_fill > max_fill) max_fill = model_fill;
    pending_results.push_back(has_exp ? exp_res : res);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(logic [CAP_W-1:0] cap, int idle, int stall, int n_ops,
                           int write_pct, bit hold);
    logic [KIND_W-1:0] kind;
    logic [AMT_W-1:0] amt;
    int ec;
    int r;
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_cap = int'(cap);
    caps_used++;
    idle_pct = idle;
    stall_pct = stall;
    want_hold = hold;
    for (int i = 0; i < n_ops; i++) begin
      ec = eff_cap();
      if ($urandom_range(99) < write_pct) begin
        kind = KIND_WRITE;
      end else begin
        r = $urandom_range(99);
        if (r < 50) kind = KIND_READ;
        else if (r < 70) kind = KIND_REWIND;
        else if (r < 90) kind = KIND_FORWARD;
        else if (r < 94) kind = KIND_CLEAR;
        else kind = KIND_SPARE_A + KIND_W'($urandom_range(2));
      end
      r = $urandom_range(99);
      if (r < 15) amt = AMT_W'($urandom_range(511));
      else if (r < 30) amt = AMT_W'($urandom_range(3));
      else if (kind == KIND_FORWARD) amt = AMT_W'($urandom_range(model_fill));
      else if (kind == KIND_REWIND && ec > model_fill)
        amt = AMT_W'($urandom_range(ec - model_fill));
      else amt = AMT_W'($urandom_range(ec));
      send_op(kind, DATA_W'($urandom_range(255)), amt, 1'b0, '0);
    end
    want_hold = 1'b0;
  endtask

  op_row_t dir_rows [25] = '{
    '{KIND_READ,    8'h00, 9'd0,   1'b1, '{8'h00, 1'b0, 1'b0, 9'd0}},
    '{KIND_FORWARD, 8'h00, 9'd1,   1'b1, '{8'h00, 1'b0, 1'b1, 9'd0}},
    '{KIND_REWIND,  8'h00, 9'd257, 1'b1, '{8'h00, 1'b0, 1'b1, 9'd0}},
    '{KIND_REWIND,  8'h00, 9'd0,   1'b1, '{8'h00, 1'b0, 1'b0, 9'd0}},
    '{KIND_FORWARD, 8'h00, 9'd0,   1'b1, '{8'h00, 1'b0, 1'b0, 9'd0}},
    '{KIND_WRITE,   8'h00, 9'd0,   1'b0, '0},
    '{KIND_WRITE,   8'hFF, 9'd0,   1'b0, '0},
    '{KIND_WRITE,   8'hA5, 9'd0,   1'b0, '0},
    '{KIND_READ,    8'h00, 9'd0,   1'b0, '0},
    '{KIND_REWIND,  8'h00, 9'd1,   1'b0, '0},
    '{KIND_READ,    8'h00, 9'd0,   1'b0, '0},
    '{KIND_FORWARD, 8'h00, 9'd2,   1'b0, '0},
    '{KIND_FORWARD, 8'h00, 9'd1,   1'b1, '{8'h00, 1'b0, 1'b1, 9'd0}},
    '{KIND_REWIND,  8'h00, 9'd256, 1'b1, '{8'h00, 1'b0, 1'b0, 9'd256}},
    '{KIND_WRITE,   8'h5A, 9'd0,   1'b1, '{8'h00, 1'b0, 1'b0, 9'd256}},
    '{KIND_READ,    8'h00, 9'd0,   1'b0, '0},
    '{KIND_SPARE_A, 8'hFF, 9'h1FF, 1'b1, '{8'h00, 1'b0, 1'b0, 9'd255}},
    '{KIND_SPARE_B, 8'hFF, 9'h1FF, 1'b1, '{8'h00, 1'b0, 1'b0, 9'd255}},
    '{KIND_SPARE_C, 8'hFF, 9'h1FF, 1'b1, '{8'h00, 1'b0, 1'b0, 9'd255}},
    '{KIND_REWIND,  8'h00, 9'h1FF, 1'b1, '{8'h00, 1'b0, 1'b1, 9'd255}},
    '{KIND_FORWARD, 8'h00, 9'h1FF, 1'b1, '{8'h00, 1'b0, 1'b1, 9'd255}},
    '{KIND_FORWARD, 8'h00, 9'd255, 1'b1, '{8'h00, 1'b0, 1'b0, 9'd0}},
    '{KIND_CLEAR,   8'h00, 9'd0,   1'b1, '{8'h00, 1'b0, 1'b0, 9'd0}},
    '{KIND_WRITE,   8'h3C, 9'd0,   1'b0, '0},
    '{KIND_READ,    8'h00, 9'd0,   1'b0, '0}
  };

  initial begin
    int mode;
    int idle;
    int stall;
    foreach (model_mem[i]) model_mem[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_op(dir_rows[i].kind, dir_rows[i].data_byte, dir_rows[i].amount,
              dir_rows[i].has_exp, dir_rows[i].exp_res);

    run_phase(9'd1,   0,  0,  90,  50, 1'b0);
    run_phase(9'd0,   63, 0,  90,  50, 1'b0);
    run_phase(9'd511, 0,  63, 150, 70, 1'b0);
    run_phase(9'd7,   6,  6,  90,  45, 1'b0);
    run_phase(9'd2,   0,  63, 90,  50, 1'b0);
    run_phase(9'd256, 0,  0,  120, 75, 1'b0);
    run_phase(9'd3,   63, 0,  80,  50, 1'b0);
    run_phase(9'd256, 0,  0,  60,  80, 1'b1);
    for (int p = 0; p < 4; p++) begin
      mode = $urandom_range(3);
      idle = (mode == 1) ? 63 : (mode == 3) ? 6 : 0;
      stall = (mode == 2) ? 63 : (mode == 3) ? 6 : 0;
      run_phase(CAP_W'($urandom_range(511)), idle, stall, 80, $urandom_range(30, 60), 1'b0);
    end
    run_phase(9'd256, 6, 6, 40, 50, 1'b0);

    drain();
    if (pending_results.size() != 0) errors++;
    $display("ran %0d beats over %0d capacity settings, %0d checked",
             beats_sent, caps_used, beats_checked);
    $display("%0d reads hit, %0d refused, peak fill %0d, %0d mismatches",
             reads_hit, refused_seen, max_fill, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== byte_ring_fifo_with_rewind_unit.f =====
src/brf_pkg.sv
src/brf_ctrl.sv
src/brf_dpath.sv
src/byte_ring_fifo_with_rewind_unit.sv
bench/tb_byte_ring_fifo_with_rewind_unit.sv
